### rtl/huffman_tree_decoder_core_assert.svh
// Assertion macros for the Huffman tree decoder checker.
`ifndef HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/htd_pkg.sv
package htd_pkg;

   localparam int SYMBOL_COUNT = 128;
   localparam int MAX_CODE_LEN = 16;
   localparam int NODE_DEPTH   = 256;

   localparam int SYM_W  = 7;
   localparam int CODE_W = 16;
   localparam int LEN_W  = 5;

   localparam int IDX_W   = $clog2(NODE_DEPTH);
   localparam int CNT_W   = $clog2(NODE_DEPTH + 1);
   localparam int STEP_W  = $clog2(CODE_W);
   localparam int LEN_MAX = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [SYM_W-1:0] sym;
   } node_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      node_type         data;
   } wr_req_type;

   typedef struct packed {
      logic [SYM_W-1:0] decoded_symbol;
      logic             symbol_valid;
      logic             store_full;
   } result_type;

endpackage

### rtl/htd_req_if.sv
interface htd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [htd_pkg::SYM_W-1:0]   symbol;
   logic [htd_pkg::CODE_W-1:0]  code_bits;
   logic [htd_pkg::LEN_W-1:0]   code_length;
   logic                        bit_req;

   modport source (output valid, op, symbol, code_bits, code_length, bit_req, input ready);
   modport sink (input valid, op, symbol, code_bits, code_length, bit_req, output ready);
endinterface

### rtl/htd_rsp_if.sv
interface htd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [htd_pkg::SYM_W-1:0]  decoded_symbol;
   logic                       symbol_valid;
   logic                       store_full;

   modport source (output valid, decoded_symbol, symbol_valid, store_full, input ready);
   modport sink (input valid, decoded_symbol, symbol_valid, store_full, output ready);
endinterface

### rtl/huffman_tree_decoder_core.sv
// Per item: decode reads the current node, then the child when one is followed; insert walks
// the path, then writes the parent and each new node; a drop for a full store or a rejected insert writes nothing.
// Throughput: one item at a time; the next is taken once the result is in the output reg.
// Rate is set by the single read port of the node store: each tree step is one dependent read.
// Reset: synchronous, active high; tree empty (root only), decode position at the root.
// No clearing pass: the root reads as empty until first written, other nodes before use.
module huffman_tree_decoder_core (
   input  logic      clock,
   input  logic      reset,
   htd_req_if.sink   req_if,
   htd_rsp_if.source rsp_if
);

   // node store access, driven by the controller
   htd_pkg::rd_req_type rd_req;
   htd_pkg::wr_req_type wr_req;
   htd_pkg::node_type   rd_data;

   // finished result from the controller, one cycle pulse
   htd_pkg::result_type res;
   logic                res_vld;

   // output register: holds the item until the sink takes it
   htd_pkg::result_type rsp_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                out_free;

   // the output register can take a new item when empty or being drained
   assign out_free = !rsp_vld_ff || rsp_if.ready;

   htd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rd_data  (rd_data),
      .rd_req   (rd_req),
      .wr_req   (wr_req),
      .out_free (out_free),
      .res_vld  (res_vld),
      .res      (res)
   );

   htd_node_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (res_vld) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload only loads on a new result, so it holds while stalled
   always_ff @(posedge clock) begin
      if (res_vld) begin
         rsp_ff <= res;
      end
   end

   assign rsp_if.valid          = rsp_vld_ff;
   assign rsp_if.decoded_symbol = rsp_ff.decoded_symbol;
   assign rsp_if.symbol_valid   = rsp_ff.symbol_valid;
   assign rsp_if.store_full     = rsp_ff.store_full;

endmodule

### rtl/htd_node_store.sv
module htd_node_store (
   input  logic                clock,
   input  logic                reset,
   input  htd_pkg::rd_req_type rd_req,
   input  htd_pkg::wr_req_type wr_req,
   output htd_pkg::node_type   rd_data
);

   htd_pkg::node_type mem [htd_pkg::NODE_DEPTH];
   htd_pkg::node_type q_ff;
   logic              root_vld_ff;
   logic              zero_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      if (rd_req.en) begin
         q_ff <= mem[rd_req.addr];
      end
   end

   // only the root can be read before it is written; it reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         root_vld_ff <= 1'b0;
         zero_ff     <= 1'b0;
      end else begin
         if (wr_req.en && (wr_req.addr == '0)) begin
            root_vld_ff <= 1'b1;
         end
         if (rd_req.en) begin
            zero_ff <= (rd_req.addr == '0) && !root_vld_ff;
         end
      end
   end

   assign rd_data = zero_ff ? '0 : q_ff;

endmodule

### rtl/htd_ctrl.sv
module htd_ctrl (
   input  logic                clock,
   input  logic                reset,
   htd_req_if.sink             req_if,
   input  htd_pkg::node_type   rd_data,
   output htd_pkg::rd_req_type rd_req,
   output htd_pkg::wr_req_type wr_req,
   input  logic                out_free,
   output logic                res_vld,
   output htd_pkg::result_type res
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_ALLOC  = 3'd2;
   localparam logic [2:0] S_FIN    = 3'd3;
   localparam logic [2:0] S_DCUR   = 3'd4;
   localparam logic [2:0] S_DCHILD = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [htd_pkg::IDX_W-1:0]   node_ff, node_in;
   logic [htd_pkg::IDX_W-1:0]   cur_ff, cur_in;
   logic [htd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [htd_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [htd_pkg::CODE_W-1:0]  code_ff, code_in;
   logic [htd_pkg::SYM_W-1:0]   sym_ff, sym_in;
   logic                        bit_ff, bit_in;
   logic                        full_ff, full_in;

   logic                        walk_bit;
   logic                        dec_bit;
   logic [htd_pkg::IDX_W-1:0]   walk_kid;
   logic [htd_pkg::IDX_W-1:0]   dec_kid;
   logic [htd_pkg::CNT_W:0]     need_sum;
   logic [htd_pkg::CNT_W-1:0]   cnt_inc;
   logic                        len_bad;
   logic                        sym_bad;
   logic                        is_leaf;

   assign walk_bit = code_ff[step_ff];
   assign walk_kid = walk_bit ? rd_data.right : rd_data.left;
   assign dec_bit  = bit_ff;
   assign dec_kid  = dec_bit ? rd_data.right : rd_data.left;
   assign need_sum = (htd_pkg::CNT_W+1)'(cnt_ff) + (htd_pkg::CNT_W+1)'(step_ff)
                     + (htd_pkg::CNT_W+1)'(1);
   assign cnt_inc  = cnt_ff + htd_pkg::CNT_W'(1);
   assign len_bad  = (req_if.code_length == '0) || (int'(req_if.code_length) > htd_pkg::LEN_MAX);
   assign sym_bad  = int'(req_if.symbol) >= htd_pkg::SYMBOL_COUNT;
   assign is_leaf  = (rd_data.left == '0) && (rd_data.right == '0);

   assign req_if.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      code_in  = code_ff;
      sym_in   = sym_ff;
      bit_in   = bit_ff;
      full_in  = full_ff;
      rd_req   = '0;
      wr_req   = '0;
      res      = '0;
      res_vld  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               code_in = req_if.code_bits;
               sym_in  = req_if.symbol;
               bit_in  = req_if.bit_req;
               full_in = 1'b0;
               if (req_if.op == htd_pkg::OP_DECODE) begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = cur_ff;
                  state_in    = S_DCUR;
               end else if (len_bad || sym_bad) begin
                  state_in = S_FIN;
               end else begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = '0;
                  node_in     = '0;
                  step_in     = htd_pkg::STEP_W'(req_if.code_length - htd_pkg::LEN_W'(1));
                  state_in    = S_WALK;
               end
            end
         end
         S_WALK: begin
            if ((step_ff != '0) && (walk_kid != '0)) begin
               node_in     = walk_kid;
               step_in     = step_ff - htd_pkg::STEP_W'(1);
               rd_req.en   = 1'b1;
               rd_req.addr = walk_kid;
            end else if (need_sum > (htd_pkg::CNT_W+1)'(htd_pkg::NODE_DEPTH)) begin
               full_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               // hook the first new node (or the leaf) into the parent
               wr_req.en   = 1'b1;
               wr_req.addr = node_ff;
               wr_req.data = rd_data;
               if (walk_bit) begin
                  wr_req.data.right = cnt_ff[htd_pkg::IDX_W-1:0];
               end else begin
                  wr_req.data.left = cnt_ff[htd_pkg::IDX_W-1:0];
               end
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            wr_req.en   = 1'b1;
            wr_req.addr = cnt_ff[htd_pkg::IDX_W-1:0];
            wr_req.data = '0;
            cnt_in      = cnt_inc;
            if (step_ff != '0) begin
               if (code_ff[step_ff - htd_pkg::STEP_W'(1)]) begin
                  wr_req.data.right = cnt_inc[htd_pkg::IDX_W-1:0];
               end else begin
                  wr_req.data.left = cnt_inc[htd_pkg::IDX_W-1:0];
               end
               step_in = step_ff - htd_pkg::STEP_W'(1);
            end else begin
               wr_req.data.sym = sym_ff;
               state_in        = S_FIN;
            end
         end
         S_FIN: begin
            res.store_full = full_ff;
            if (out_free) begin
               res_vld  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DCUR: begin
            if (dec_kid == '0) begin
               if (out_free) begin
                  res_vld  = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               node_in     = dec_kid;
               rd_req.en   = 1'b1;
               rd_req.addr = dec_kid;
               state_in    = S_DCHILD;
            end
         end
         S_DCHILD: begin
            res.symbol_valid   = is_leaf;
            res.decoded_symbol = is_leaf ? rd_data.sym : '0;
            if (out_free) begin
               res_vld  = 1'b1;
               cur_in   = is_leaf ? '0 : node_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff   <= '0;
         cnt_ff   <= htd_pkg::CNT_W'(1);
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      step_ff <= step_in;
      code_ff <= code_in;
      sym_ff  <= sym_in;
      bit_ff  <= bit_in;
      full_ff <= full_in;
   end

endmodule

### rtl/huffman_tree_decoder_core_chk.sv
`include "huffman_tree_decoder_core_assert.svh"

module huffman_tree_decoder_core_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [htd_pkg::SYM_W-1:0] decoded_symbol,
   input logic                      symbol_valid,
   input logic                      store_full
);

   `HTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped while stalled")
   `HTD_ASSERT_SAME(a_flags_excl, clock, reset, rsp_valid, !(symbol_valid && store_full), "symbol and full flags both set")
   `HTD_ASSERT_SAME(a_sym_zero, clock, reset, rsp_valid && !symbol_valid, decoded_symbol == '0, "symbol without valid flag")
   `HTD_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")

endmodule

bind huffman_tree_decoder_core huffman_tree_decoder_core_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .decoded_symbol (rsp_if.decoded_symbol),
   .symbol_valid   (rsp_if.symbol_valid),
   .store_full     (rsp_if.store_full)
);

### dv/tb.sv
`timescale 1ns / 1ps

// Huffman tree decoder testbench.
// A shadow copy of the node store predicts one result for every accepted item.
// Those results queue up, and each result the block returns is compared
// against the oldest one.
// Both channels use valid/ready and take random per-item waits. Some
// stretches run with no waits on either side.
module tb;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_FILL       = 200;   // random inserts stop here, store fill is its own test

   typedef struct {
      logic                             op;
      logic [htd_pkg::SYM_W-1:0]        symbol;
      logic [htd_pkg::CODE_W-1:0]       code_bits;
      logic [htd_pkg::LEN_W-1:0]        code_length;
      logic                             bit_req;
   } tree_item_type;

   // codeword as inserted, replayed MSB first to build decode traffic
   typedef struct {
      logic [htd_pkg::CODE_W-1:0] bits;
      int                         len;
   } codeword_type;

   logic clock = 1'b0;
   logic reset;

   htd_req_if req_bus ();
   htd_rsp_if rsp_bus ();

   huffman_tree_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow tree: entry 0 is the root, a child index of 0 means no child
   htd_pkg::node_type   shadow_node [htd_pkg::NODE_DEPTH];
   int                  nodes_alloc;
   int                  decode_pos;
   htd_pkg::result_type pending_results [$];
   codeword_type        known_codes [$];

   int          mismatch_count = 0;
   int          items_sent     = 0;
   bit          no_idle        = 1'b0;
   int          idle_cycles    = 0;
   bit          req_fire       = 1'b0;
   bit          rsp_fire       = 1'b0;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------
   function automatic int child_index(int node, logic dir);
      return dir ? int'(shadow_node[node].right) : int'(shadow_node[node].left);
   endfunction

   function automatic void attach_child(int node, logic dir, int kid);
      if (dir) begin
         shadow_node[node].right = kid[htd_pkg::IDX_W-1:0];
      end else begin
         shadow_node[node].left = kid[htd_pkg::IDX_W-1:0];
      end
   endfunction

   function automatic htd_pkg::result_type predict_tree_result(tree_item_type it);
      htd_pkg::result_type res;
      int                  len;
      int                  need;
      int                  node;
      int                  nxt;
      int                  i;
      bit                  walking;

      res = '0;

      if (it.op == htd_pkg::OP_DECODE) begin
         // a missing child leaves the position where it is
         nxt = child_index(decode_pos, it.bit_req);
         if (nxt != 0) begin
            decode_pos = nxt;
         end
         // a leaf is any non-root node with no children; the empty root never emits
         if (decode_pos != 0 && shadow_node[decode_pos].left == '0 &&
             shadow_node[decode_pos].right == '0) begin
            res.decoded_symbol = shadow_node[decode_pos].sym;
            res.symbol_valid   = 1'b1;
            decode_pos         = 0;
         end
         return res;
      end

      // bad length or symbol: tree untouched, no flag
      len = int'(it.code_length);
      if (len == 0 || len > htd_pkg::LEN_MAX ||
          int'(it.symbol) >= htd_pkg::SYMBOL_COUNT) begin
         return res;
      end

      // dry run: missing path nodes plus the new leaf must all fit
      node    = 0;
      need    = 1;
      walking = 1'b1;
      for (i = len - 1; i >= 1; i--) begin
         if (walking) begin
            nxt = child_index(node, it.code_bits[i]);
            if (nxt == 0) begin
               walking = 1'b0;
            end else begin
               node = nxt;
            end
         end
         if (!walking) begin
            need++;
         end
      end
      if (nodes_alloc + need > htd_pkg::NODE_DEPTH) begin
         res.store_full = 1'b1;
         return res;
      end

      // commit: a leaf on the path simply gains children
      node = 0;
      for (i = len - 1; i >= 1; i--) begin
         nxt = child_index(node, it.code_bits[i]);
         if (nxt == 0) begin
            nxt = nodes_alloc;
            nodes_alloc++;
            shadow_node[nxt] = '0;
            attach_child(node, it.code_bits[i], nxt);
         end
         node = nxt;
      end
      // last bit always gets a fresh leaf; any old subtree there is orphaned
      nxt = nodes_alloc;
      nodes_alloc++;
      shadow_node[nxt]     = '0;
      shadow_node[nxt].sym = it.symbol;
      attach_child(node, it.code_bits[0], nxt);
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Item builders; fields the op ignores are random
   // ---------------------------------------------------------------------------
   function automatic tree_item_type insert_item(int sym, logic [htd_pkg::CODE_W-1:0] bits,
                                                 int len);
      tree_item_type it;
      it.op          = htd_pkg::OP_INSERT;
      it.symbol      = sym[htd_pkg::SYM_W-1:0];
      it.code_bits   = bits;
      it.code_length = len[htd_pkg::LEN_W-1:0];
      it.bit_req     = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic tree_item_type bit_item(logic b);
      tree_item_type it;
      it.op          = htd_pkg::OP_DECODE;
      it.symbol      = htd_pkg::SYM_W'($urandom);
      it.code_bits   = htd_pkg::CODE_W'($urandom);
      it.code_length = htd_pkg::LEN_W'($urandom);
      it.bit_req     = b;
      return it;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender. Valid stays high after an accept so a back-to-back item never
   // sees valid lowered and raised in one step; it drops only on a gap or drain.
   // ---------------------------------------------------------------------------
   task automatic send_item(tree_item_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= it.op;
      req_bus.symbol      <= it.symbol;
      req_bus.code_bits   <= it.code_bits;
      req_bus.code_length <= it.code_length;
      req_bus.bit_req     <= it.bit_req;
      // inputs only move at rising edges, so ready is settled at the falling edge
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      pending_results.push_back(predict_tree_result(it));
      items_sent++;
   endtask

   task automatic insert_code(int sym, logic [htd_pkg::CODE_W-1:0] bits, int len);
      send_item(insert_item(sym, bits, len));
      known_codes.push_back('{bits: bits, len: len});
   endtask

   task automatic send_codeword(codeword_type cw);
      int i;
      for (i = cw.len - 1; i >= 0; i--) begin
         send_item(bit_item(cw.bits[i]));
      end
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // decode on a bare root, then inserts with lengths the block must reject
   task automatic test_empty_tree();
      send_item(bit_item(1'b0));
      send_item(bit_item(1'b1));
      send_item(insert_item($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                            htd_pkg::CODE_W'($urandom), 0));
      send_item(insert_item($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                            htd_pkg::CODE_W'($urandom), htd_pkg::LEN_MAX + 1));
      send_item(insert_item($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                            htd_pkg::CODE_W'($urandom), (1 << htd_pkg::LEN_W) - 1));
   endtask

   // small hand-built tree: extremes of symbol and length, missing child,
   // leaf replacement and a long code routed through an existing leaf
   task automatic test_directed_codes();
      insert_code(htd_pkg::SYMBOL_COUNT - 1, 16'hFFFE, 1);  // "0", unused high bits all set
      insert_code(0, 16'h0002, 2);                          // "10"
      send_item(bit_item(1'b0));                            // leaf "0"
      send_item(bit_item(1'b1));                            // internal, nothing yet
      send_item(bit_item(1'b1));                            // "11" absent, stay put
      send_item(bit_item(1'b0));                            // leaf "10"
      insert_code(7'h55, 16'h0003, 2);                      // "11"
      insert_code(7'h2A, 16'h0000, 1);                      // replaces leaf "0"
      send_item(bit_item(1'b0));
      insert_code(7'h3C, 16'hFFFF, htd_pkg::LEN_MAX);       // runs through leaf "11"
      send_item(bit_item(1'b1));
      send_item(bit_item(1'b1));                            // "11" is internal now
   endtask

   // mostly replayed codewords, some fresh inserts while the store has room,
   // plus noise: lone bits and rejected lengths
   task automatic test_random_traffic(int n_items);
      int           stop_at;
      int           next_window;
      int           pick;
      int           len;
      codeword_type cw;

      stop_at     = items_sent + n_items;
      next_window = items_sent;
      while (items_sent < stop_at) begin
         if (items_sent >= next_window) begin
            no_idle     = ($urandom_range(0, 3) == 0);
            next_window = items_sent + $urandom_range(50, 200);
         end
         pick = $urandom_range(0, 99);
         if (pick < 6 && nodes_alloc < MAX_FILL) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, htd_pkg::LEN_MAX)
                                              : $urandom_range(1, 6);
            insert_code($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                        htd_pkg::CODE_W'($urandom), len);
         end else if (pick < 10) begin
            len = ($urandom_range(0, 1) == 0) ? 0
                  : $urandom_range(htd_pkg::LEN_MAX + 1, (1 << htd_pkg::LEN_W) - 1);
            send_item(insert_item($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                                  htd_pkg::CODE_W'($urandom), len));
         end else if (pick < 20) begin
            send_item(bit_item(1'($urandom_range(0, 1))));
         end else begin
            cw = known_codes[$urandom_range(0, known_codes.size() - 1)];
            send_codeword(cw);
         end
      end
      no_idle = 1'b0;
   endtask

   // fill every entry, then inserts that cannot fit must raise store_full
   task automatic test_store_full();
      while (nodes_alloc + htd_pkg::LEN_MAX <= htd_pkg::NODE_DEPTH) begin
         insert_code($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                     htd_pkg::CODE_W'($urandom), htd_pkg::LEN_MAX);
      end
      repeat (3) insert_code($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                             htd_pkg::CODE_W'($urandom), htd_pkg::LEN_MAX);
      // length-one codes need exactly one entry each
      while (nodes_alloc < htd_pkg::NODE_DEPTH) begin
         insert_code($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                     htd_pkg::CODE_W'($urandom), 1);
      end
      insert_code($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1), htd_pkg::CODE_W'($urandom), 1);
      insert_code($urandom_range(0, htd_pkg::SYMBOL_COUNT - 1),
                  htd_pkg::CODE_W'($urandom), htd_pkg::LEN_MAX);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stalls, capture at the falling edge, compare at accept
   // ---------------------------------------------------------------------------
   function automatic void log_mismatch(string what, htd_pkg::result_type want,
                                        htd_pkg::result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected sym=%0d valid=%0b full=%0b, got sym=%0d valid=%0b full=%0b",
                  $realtime, what, want.decoded_symbol, want.symbol_valid, want.store_full,
                  got.decoded_symbol, got.symbol_valid, got.store_full);
      end
   endfunction

   initial begin : result_checker
      htd_pkg::result_type got;
      htd_pkg::result_type want;
      int                  stall;

      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(negedge clock); while (!rsp_bus.valid);
         got.decoded_symbol = rsp_bus.decoded_symbol;
         got.symbol_valid   = rsp_bus.symbol_valid;
         got.store_full     = rsp_bus.store_full;
         @(posedge clock);
         if (pending_results.size() == 0) begin
            log_mismatch("result with nothing expected", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.decoded_symbol !== want.decoded_symbol) begin
               log_mismatch("decoded_symbol", want, got);
            end
            if (got.symbol_valid !== want.symbol_valid) begin
               log_mismatch("symbol_valid", want, got);
            end
            if (got.store_full !== want.store_full) begin
               log_mismatch("store_full", want, got);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: handshakes seen at the falling edge, counted at the rising one
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
   end

   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.op          <= htd_pkg::OP_INSERT;
      req_bus.symbol      <= '0;
      req_bus.code_bits   <= '0;
      req_bus.code_length <= '0;
      req_bus.bit_req     <= 1'b0;
      foreach (shadow_node[i]) shadow_node[i] = '0;
      nodes_alloc = 1;  // root only
      decode_pos  = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_tree();
      test_directed_codes();
      test_random_traffic(800);
      wait_for_drain();  // sender holds off until the block is empty
      test_random_traffic(800);
      test_store_full();
      test_random_traffic(150);  // full store: no fresh inserts, only decodes and rejected lengths; inserts all dropped

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/htd_pkg.sv
rtl/htd_req_if.sv
rtl/htd_rsp_if.sv
rtl/htd_node_store.sv
rtl/htd_ctrl.sv
rtl/huffman_tree_decoder_core.sv
rtl/huffman_tree_decoder_core_chk.sv
dv/tb.sv
